/* src/sm_pkg.sv */
// sm_pkg: shared types, constants and the exponential table for the softmax unit
// no dependencies; used by sm_div, softmax_unit and the testbench
`default_nettype none

package sm_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int NUM_W        = 57;
  localparam int DEN_W        = 45;
  localparam int QUOT_W       = 16;
  localparam int SUM_W        = 23;
  localparam int EXP_W        = 17;
  localparam int MUL_W        = 24;
  localparam logic [MUL_W-1:0] LOG2E_Q16 = 24'd94548;

  typedef enum logic [3:0] {
    S_LOAD,
    S_RD,
    S_MUL_T,
    S_MUL_R,
    S_EXP,
    S_MUL_D,
    S_MUL_N,
    S_DIV_GO,
    S_DIV,
    S_OUT
  } sm_state_t;

  // 2^(-k/16) in Q16, k = 0..16
  function automatic logic [EXP_W-1:0] pow2_neg(input logic [4:0] k);
    logic [EXP_W-1:0] v;
    case (k)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      5'd16:   v = 17'd32768;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* src/sm_ram.sv */
// sm_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module sm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/sm_div.sv */
// sm_div: restoring divider, one quotient bit a cycle, 16-bit saturated quotient
// depends on sm_pkg
`default_nettype none

module sm_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [sm_pkg::NUM_W-1:0]   num,
  input  wire logic [sm_pkg::DEN_W-1:0]   den,
  output logic                            done,
  output logic      [sm_pkg::QUOT_W-1:0]  quot
);
  import sm_pkg::*;

  localparam int SH_W = DEN_W + QUOT_W;

  logic              running;
  logic [4:0]        cnt;
  logic [NUM_W-1:0]  rem;
  logic [SH_W-1:0]   dsh;
  logic [QUOT_W-1:0] q;
  logic              sat;
  logic              fits;

  assign fits = {{(SH_W-NUM_W){1'b0}}, rem} >= dsh;
  assign quot = sat ? {QUOT_W{1'b1}} : q;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= 5'd16;
      end else if (running) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // datapath: first step decides saturation, then sixteen quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsh <= {den, {QUOT_W{1'b0}}};
      q   <= '0;
      sat <= 1'b0;
    end else if (running) begin
      if (fits) begin
        rem <= rem - dsh[NUM_W-1:0];
        if (cnt[4]) begin
          sat <= 1'b1;
        end else begin
          q[cnt[3:0]] <= 1'b1;
        end
      end
      dsh <= dsh >> 1;
    end
  end

endmodule

`default_nettype wire

/* src/softmax_unit.sv */
// softmax_unit: top level, sequencer with shared multiplier, element store and divider
// depends on sm_pkg, sm_ram and sm_div
`default_nettype none

// Softmax over a vector of signed Q8.8 elements. Elements are taken one per cycle
// while busy is low; up to 64 are stored, later ones are dropped and flagged. The
// element with last_element set starts the computation and busy stays high until
// every result has been sent. The sequencer then makes two passes over the store,
// using one shared 24x24 multiplier: a summing pass through S_RD, S_MUL_T, S_MUL_R
// and S_EXP for each element, and an output pass that adds S_DIV_GO, S_DIV and
// S_OUT, plus S_MUL_D and S_MUL_N in derivative mode; S_DIV waits for the 17 steps
// of the bit-serial divider. Each result appears for exactly one cycle with
// result_valid high; there is no back-pressure, so the receiver must take every
// result as it comes. output_mode is sampled when the last element is accepted.
module softmax_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] element_value,
  input  wire logic        last_element,
  input  wire logic        mode_wr_en,
  input  wire logic        mode_wr_data,
  output logic             result_valid,
  output logic      [15:0] result_value,
  output logic             last_result,
  output logic             elements_dropped
);
  import sm_pkg::*;

  sm_state_t         state, state_next;
  logic              output_mode;
  logic              mode_act;
  logic              pass;
  logic [IDX_W-1:0]  idx;
  logic [CNT_W-1:0]  count;
  logic signed [15:0] run_max;
  logic [SUM_W-1:0]  exp_total;
  logic              ovf;
  logic [8:0]        yreg;
  logic [EXP_W-1:0]  hi_reg;
  logic [EXP_W-1:0]  e_reg;
  logic [DEN_W-1:0]  d_reg;
  logic [2*MUL_W-1:0] prod;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [15:0]       rdata;
  logic              accept;
  logic              store_en;
  logic              idx_last;
  logic              div_start, div_done;
  logic [QUOT_W-1:0] div_quot;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic [15:0]       t_val;
  logic [4:0]        tk;
  logic [EXP_W-1:0]  tab_hi, tab_lo;
  logic [24:0]       interp;
  logic [EXP_W-1:0]  m_val;
  logic [17:0]       rnd_sum;
  logic [EXP_W-1:0]  e_comb;
  logic [SUM_W-1:0]  rest;

  assign accept   = start && !busy;
  assign store_en = accept && (count < CNT_W'(MAX_ELEMENTS));
  assign idx_last = ({1'b0, idx} + CNT_W'(1)) == count;

  // element store
  sm_ram #(.WIDTH(16), .DEPTH(MAX_ELEMENTS)) u_store (
    .clk   (clk),
    .we    (store_en),
    .waddr (count[IDX_W-1:0]),
    .wdata (element_value),
    .raddr (idx),
    .rdata (rdata)
  );

  // exponential: table lookup, interpolation and rounding shift
  assign t_val  = 16'(run_max - $signed(rdata));
  assign tk     = {1'b0, prod[23:20]};
  assign tab_hi = pow2_neg(tk);
  assign tab_lo = pow2_neg(tk + 5'd1);
  assign interp = {1'b0, prod[23:0]} + 25'd2048;
  assign m_val  = hi_reg - {4'b0, interp[24:12]};
  assign rnd_sum = {1'b0, m_val} + (18'd1 << (yreg[4:0] - 5'd1));

  always_comb begin
    if (yreg == 9'd0) begin
      e_comb = m_val;
    end else if (yreg > 9'd17) begin
      e_comb = '0;
    end else begin
      e_comb = EXP_W'(rnd_sum >> yreg[4:0]);
    end
  end

  assign rest = (exp_total >= SUM_W'(e_reg)) ? exp_total - SUM_W'(e_reg) : '0;

  // divider operands
  always_comb begin
    if (mode_act) begin
      div_num = NUM_W'({prod[39:0], 16'b0}) + NUM_W'(d_reg >> 1);
      div_den = d_reg;
    end else begin
      div_num = NUM_W'({e_reg, 16'b0}) + NUM_W'(exp_total >> 1);
      div_den = DEN_W'(exp_total);
    end
  end

  sm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_LOAD:   if (accept && last_element) state_next = S_RD;
      S_RD:     state_next = S_MUL_T;
      S_MUL_T:  state_next = S_MUL_R;
      S_MUL_R:  state_next = S_EXP;
      S_EXP: begin
        if (!pass) begin
          state_next = S_RD;
        end else if (mode_act) begin
          state_next = S_MUL_D;
        end else begin
          state_next = S_DIV_GO;
        end
      end
      S_MUL_D:  state_next = S_MUL_N;
      S_MUL_N:  state_next = S_DIV_GO;
      S_DIV_GO: state_next = S_DIV;
      S_DIV:    if (div_done) state_next = S_OUT;
      S_OUT:    state_next = idx_last ? S_LOAD : S_RD;
      default:  state_next = S_LOAD;
    endcase
  end

  // outputs of the sequencer and multiplier operand select
  always_comb begin
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    busy         = (state != S_LOAD);
    result_valid = (state == S_OUT);
    case (state)
      S_MUL_T: begin
        mul_a = {8'b0, t_val};
        mul_b = LOG2E_Q16;
      end
      S_MUL_R: begin
        mul_a = MUL_W'(tab_hi - tab_lo);
        mul_b = {12'b0, prod[19:8]};
      end
      S_MUL_D: begin
        mul_a = MUL_W'(exp_total);
        mul_b = MUL_W'(exp_total);
      end
      S_MUL_N: begin
        mul_a = MUL_W'(e_reg);
        mul_b = MUL_W'(rest);
      end
      S_DIV_GO: div_start = 1'b1;
      default: begin
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // shared multiplier, registered
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // control and vector state
  always_ff @(posedge clk) begin
    if (rst) begin
      output_mode <= 1'b0;
      mode_act    <= 1'b0;
      pass        <= 1'b0;
      idx         <= '0;
      count       <= '0;
      run_max     <= 16'sh8000;
      exp_total   <= '0;
      ovf         <= 1'b0;
    end else begin
      if (mode_wr_en) begin
        output_mode <= mode_wr_data;
      end
      case (state)
        S_LOAD: begin
          if (accept) begin
            if (store_en) begin
              count <= count + CNT_W'(1);
              if ($signed(element_value) > run_max) begin
                run_max <= $signed(element_value);
              end
            end else begin
              ovf <= 1'b1;
            end
            if (last_element) begin
              mode_act  <= output_mode;
              pass      <= 1'b0;
              idx       <= '0;
              exp_total <= '0;
            end
          end
        end
        S_EXP: begin
          if (!pass) begin
            exp_total <= exp_total + SUM_W'(e_comb);
            if (idx_last) begin
              pass <= 1'b1;
              idx  <= '0;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        S_OUT: begin
          if (idx_last) begin
            count     <= '0;
            run_max   <= 16'sh8000;
            exp_total <= '0;
            ovf       <= 1'b0;
            pass      <= 1'b0;
            idx       <= '0;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_MUL_R) begin
      yreg   <= prod[32:24];
      hi_reg <= tab_hi;
    end
    if (state == S_EXP) begin
      e_reg <= e_comb;
    end
    if (state == S_MUL_N) begin
      d_reg <= prod[DEN_W-1:0];
    end
    if (state == S_DIV && div_done) begin
      result_value     <= div_quot;
      last_result      <= idx_last;
      elements_dropped <= ovf;
    end
  end

`ifndef SYNTH
  // a result only goes out inside a vector's computation
  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy) else $error("result outside computation");

  // the last element starts the computation
  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last_element) |=> busy) else $error("last element ignored");

  // the final result of a vector frees the block
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_result) |=> !busy) else $error("block stuck after last result");

  // stored count never exceeds the store
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ELEMENTS)) else $error("element count beyond capacity");
`endif

endmodule

`default_nettype wire

/* dv/softmax_unit_tb.sv */
// softmax_unit_tb: self-checking testbench for the softmax unit
// drives random and directed vectors, predicts results in-bench; depends on sm_pkg and the rtl
`timescale 1ns / 100ps

module softmax_unit_tb;
  import sm_pkg::*;

  typedef struct packed {
    logic [15:0] value;
    logic        last;
  } elem_t;

  typedef struct packed {
    logic [15:0] value;
    logic        last;
    logic        dropped;
  } sm_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [15:0] element_value = '0;
  logic        last_element = 1'b0;
  logic        mode_wr_en = 1'b0;
  logic        mode_wr_data = 1'b0;
  wire         busy;
  wire         result_valid;
  wire  [15:0] result_value;
  wire         last_result;
  wire         elements_dropped;

  softmax_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .element_value(element_value), .last_element(last_element),
    .mode_wr_en(mode_wr_en), .mode_wr_data(mode_wr_data),
    .result_valid(result_valid), .result_value(result_value),
    .last_result(last_result), .elements_dropped(elements_dropped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [15:0] vec_store [MAX_ELEMENTS];
  int          vec_count;
  logic signed [15:0] vec_max;
  bit          vec_overflow;
  bit          pred_mode;

  elem_t       pending_elems [$];
  sm_result_t  expected_results [$];
  int          error_count = 0;
  int          gap_left = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [EXP_W-1:0] table_pow2(int k);
    case (k)
      0: return 17'd65536;   1: return 17'd62757;   2: return 17'd60097;
      3: return 17'd57549;   4: return 17'd55109;   5: return 17'd52773;
      6: return 17'd50535;   7: return 17'd48393;   8: return 17'd46341;
      9: return 17'd44376;  10: return 17'd42495;  11: return 17'd40693;
      12: return 17'd38968; 13: return 17'd37316;  14: return 17'd35734;
      15: return 17'd34219;
      default: return 17'd32768;
    endcase
  endfunction

  // exp(-t) with t in Q8.8, result in Q1.16
  function automatic longint unsigned exp_neg(longint unsigned t);
    longint unsigned p, y, f, k, r, hi, lo, m;
    p  = t * 94548;
    y  = p >> 24;
    f  = (p >> 8) & 16'hFFFF;
    k  = f >> 12;
    r  = f & 12'hFFF;
    hi = table_pow2(int'(k));
    lo = table_pow2(int'(k) + 1);
    m  = hi - (((hi - lo) * r + 2048) >> 12);
    if (y >= 32) return 0;
    if (y == 0) return m;
    return (m + (64'd1 << (y - 1))) >> y;
  endfunction

  task automatic clear_vec();
    vec_count = 0;
    vec_max = 16'sh8000;
    vec_overflow = 1'b0;
  endtask

  // one accepted element: update state, emit expected results on last
  task automatic predict_elem(elem_t it);
    longint unsigned s, e, q, d, rest;
    sm_result_t res;
    if (vec_count < MAX_ELEMENTS) begin
      vec_store[vec_count] = it.value;
      vec_count++;
      if ($signed(it.value) > vec_max) vec_max = $signed(it.value);
    end else begin
      vec_overflow = 1'b1;
    end
    if (!it.last) return;
    s = 0;
    for (int i = 0; i < vec_count; i++)
      s += exp_neg(longint'(vec_max) - longint'($signed(vec_store[i])));
    s &= 23'h7FFFFF;
    for (int i = 0; i < vec_count; i++) begin
      e = exp_neg(longint'(vec_max) - longint'($signed(vec_store[i])));
      q = 0;
      if (!pred_mode) begin
        if (s != 0) q = ((e << 16) + (s >> 1)) / s;
      end else begin
        d = s * s;
        rest = (s >= e) ? s - e : 0;
        if (d != 0) q = (((e * rest) << 16) + (d >> 1)) / d;
      end
      if (q > 16'hFFFF) q = 16'hFFFF;
      res.value = q[15:0];
      res.last = (i + 1 == vec_count);
      res.dropped = vec_overflow;
      expected_results.push_back(res);
    end
    clear_vec();
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      predict_elem({element_value, last_element});
      gap_left = pick_gap();
      if (gap_left == 0 && pending_elems.size() > 0) begin
        elem_t it;
        it = pending_elems.pop_front();
        element_value <= it.value;
        last_element <= it.last;
      end else begin
        start <= 1'b0;
      end
    end else if (!start) begin
      if (gap_left > 0) gap_left--;
      else if (pending_elems.size() > 0) begin
        elem_t it;
        it = pending_elems.pop_front();
        element_value <= it.value;
        last_element <= it.last;
        start <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", result_value, -1);
      end else begin
        sm_result_t w;
        w = expected_results.pop_front();
        if (result_value !== w.value) report_mismatch("result_value", result_value, w.value);
        if (last_result !== w.last) report_mismatch("last_result", last_result, w.last);
        if (elements_dropped !== w.dropped)
          report_mismatch("elements_dropped", elements_dropped, w.dropped);
      end
    end
  end

  task automatic queue_elem(logic [15:0] v, logic l);
    elem_t it;
    it.value = v;
    it.last = l;
    pending_elems.push_back(it);
  endtask

  // well-formed random vector; wide picks wide or narrow values
  task automatic queue_vector(int len, bit wide);
    logic [15:0] v;
    for (int i = 0; i < len; i++) begin
      if (wide) v = 16'($urandom);
      else v = 16'($urandom_range(0, 2047) - 1024);
      queue_elem(v, i == len - 1);
    end
  endtask

  // wait until driver and block are quiet, then write the mode register
  task automatic set_mode(bit m);
    while (pending_elems.size() > 0 || start || busy || expected_results.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
    mode_wr_en <= 1'b1;
    mode_wr_data <= m;
    pred_mode = m;
    @(posedge clk);
    mode_wr_en <= 1'b0;
  endtask

  initial begin
    clear_vec();
    pred_mode = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: single element, extremes, equal values, mixed values
    for (int m = 0; m < 2; m++) begin
      set_mode(m);
      queue_elem(16'h0000, 1'b1);
      queue_elem(16'h7FFF, 1'b0); queue_elem(16'h8000, 1'b1);
      queue_elem(16'h0100, 1'b0); queue_elem(16'h0100, 1'b0); queue_elem(16'h0100, 1'b1);
      queue_elem(16'hFFFF, 1'b0); queue_elem(16'h5555, 1'b0); queue_elem(16'hAAAA, 1'b1);
    end
    set_mode(1'b0);
    // capacity exceeded, with the dropped element carrying the last mark
    for (int i = 0; i < MAX_ELEMENTS + 2; i++)
      queue_elem(16'($urandom), i == MAX_ELEMENTS + 1);

    // random phases over both modes
    for (int ph = 0; ph < 6; ph++) begin
      set_mode(ph[0]);
      for (int v = 0; v < 2; v++) begin
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
        queue_vector(len, $urandom_range(0, 1));
      end
    end
    while (pending_elems.size() > 0 || start || busy || expected_results.size() > 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("softmax_unit test passed");
    end else begin
      $display("softmax_unit test failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("softmax_unit test failed");
    $finish;
  end

endmodule
